FILE: hdl/psa_pkg.sv
// Shared constants for the page slot allocator: field widths, actions and status codes.
// No dependencies; used by page_slot_allocator.
`default_nettype none
package psa_pkg;
	localparam int PAGE_W   = 6;
	localparam int SLOT_W   = 6;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 7;
	localparam int BYTE_W   = 8;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_PAGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

	localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;
endpackage
`default_nettype wire

FILE: hdl/page_slot_allocator.sv
// Page slot allocator top level: APB register, page metadata memory and the allocation sequencer.
// Depends on psa_pkg.
// A request is accepted only while the block is idle, and the block stays busy until the result
// has been loaded into the output register. An insert that opens a new page passes through the
// scan, write and result states; an insert into a page taken from the list first passes through
// the load state, then scan, write and result, with the byte-wide free-slot scanner stepping
// through 1 to ceil(SLOTS/8) bitmap bytes; a delete passes through load and result, and a refused
// insert goes straight to the result state. The next request can be accepted in the cycle after
// that load. A result still waiting in the output register holds back the following result,
// not the following request. No clearing pass follows reset: pages are opened in order and
// initialized as they are opened.
`default_nettype none
module page_slot_allocator #(
	parameter int PAGES = 64,
	parameter int SLOTS = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [5:0] page, [11:6] slot, rest zero
	input  wire  [0:0]  s_tuser,   // [0] action
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [5:0] out_page, [11:6] out_slot, rest zero
	output logic [1:0]  m_tuser,   // [1:0] status
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int PW     = $clog2(PAGES + 1);
	localparam int AW     = $clog2(PAGES);
	localparam int CW     = (PW > psa_pkg::PAGE_W) ? PW : psa_pkg::PAGE_W;
	localparam int CNTW   = $clog2(SLOTS + 1);
	localparam int SW     = $clog2(SLOTS);
	localparam int NBYTES = (SLOTS + 7) / 8;
	localparam int BW     = (NBYTES > 1) ? $clog2(NBYTES) : 1;
	localparam int RW     = NBYTES * 8;
	localparam logic [PW-1:0] LIST_END = PW'(PAGES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_RES  = 3'd4;

	typedef struct packed {
		logic [PW-1:0]   nxt;
		logic [CNTW-1:0] cnt;
		logic [SLOTS-1:0] bits;
	} row_t;

	row_t mem [PAGES];
	row_t rdata_q;
	row_t wdata_c;
	logic we_c;
	logic [AW-1:0] waddr_c;
	logic [AW-1:0] raddr_c;

	logic [2:0] state_q;
	localparam int CFG_W_L = psa_pkg::CFG_W;
	logic [CFG_W_L-1:0] spp_q;
	logic [PW-1:0] head_q;
	logic [PW-1:0] pages_q;
	logic act_q;
	logic [psa_pkg::PAGE_W-1:0] ipage_q;
	logic [psa_pkg::SLOT_W-1:0] islot_q;
	logic [AW-1:0] p_q;
	logic [SW-1:0] slot_q;
	logic [SLOTS-1:0] bits_q;
	logic [CNTW-1:0] cnt_q;
	logic [PW-1:0] nxt_q;
	logic [BW-1:0] byte_q;
	logic [psa_pkg::STATUS_W-1:0] res_st_q;
	logic [psa_pkg::PAGE_W-1:0] res_page_q;
	logic [psa_pkg::SLOT_W-1:0] res_slot_q;
	logic m_tvalid_q;
	logic [psa_pkg::STATUS_W-1:0] out_st_q;
	logic [psa_pkg::PAGE_W-1:0] out_page_q;
	logic [psa_pkg::SLOT_W-1:0] out_slot_q;

	logic accept;
	logic cfg_wr;
	logic [CNTW-1:0] eff_c;
	logic [8:0] spp_w;
	logic [CW-1:0] ip_ext;
	logic [CW-1:0] pages_ext;
	logic [CW-1:0] in_page_ext;
	logic [SLOTS-1:0] islot_mask;
	logic [SLOTS-1:0] slot_mask;
	logic bad_c;
	logic [RW-1:0] pad_c;
	logic [RW-1:0] pad_sh;
	logic [7:0] byte_c;
	logic [2:0] lz_c;
	logic [BW+2:0] found_c;
	logic [CNTW-1:0] cnt_dec;
	logic [SW+5:0] slot_wide;
	logic [AW+5:0] page_wide;
	logic res_load;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign cfg_wr   = psel && penable && pwrite && pready && !paddr[2];
	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? 32'd0 : {25'd0, spp_q};

	assign spp_w = {2'b00, spp_q};
	always_comb begin
		if (spp_w == 9'd0) begin
			eff_c = CNTW'(1);
		end else if (spp_w > 9'(SLOTS)) begin
			eff_c = CNTW'(SLOTS);
		end else begin
			eff_c = CNTW'(spp_w);
		end
	end

	assign ip_ext      = CW'(ipage_q);
	assign pages_ext   = CW'(pages_q);
	assign in_page_ext = CW'(s_tdata[psa_pkg::PAGE_W-1:0]);
	assign islot_mask  = SLOTS'(1) << islot_q;
	assign slot_mask   = SLOTS'(1) << slot_q;
	assign bad_c = (ip_ext >= pages_ext) || (9'(islot_q) >= 9'(SLOTS))
		|| ((rdata_q.bits & islot_mask) == '0);

	always_comb begin
		pad_c = '1;
		pad_c[SLOTS-1:0] = bits_q;
	end
	assign pad_sh = pad_c >> {byte_q, 3'b000};
	assign byte_c = pad_sh[7:0];
	always_comb begin
		lz_c = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!byte_c[i]) begin
				lz_c = 3'(i);
			end
		end
	end
	assign found_c = {byte_q, lz_c};
	assign cnt_dec = (cnt_q != '0) ? cnt_q - CNTW'(1) : '0;
	assign slot_wide = {6'd0, slot_q};
	assign page_wide = {6'd0, p_q};

	assign raddr_c = (s_tuser[0] == psa_pkg::ACT_DELETE) ? in_page_ext[AW-1:0] : head_q[AW-1:0];

	always_comb begin
		we_c    = 1'b0;
		waddr_c = p_q;
		wdata_c = rdata_q;
		unique case (state_q)
			S_LOAD: begin
				waddr_c = ip_ext[AW-1:0];
				wdata_c.bits = rdata_q.bits & ~islot_mask;
				wdata_c.cnt  = rdata_q.cnt + CNTW'(1);
				wdata_c.nxt  = (rdata_q.cnt == '0) ? head_q : rdata_q.nxt;
				we_c = (act_q == psa_pkg::ACT_DELETE) && !bad_c;
			end
			S_WR: begin
				wdata_c.bits = bits_q | slot_mask;
				wdata_c.cnt  = cnt_dec;
				wdata_c.nxt  = (cnt_dec == '0) ? LIST_END : nxt_q;
				we_c = 1'b1;
			end
			default: begin
				we_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[waddr_c] <= wdata_c;
		end
		rdata_q <= mem[raddr_c];
	end

	assign res_load = (state_q == S_RES) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			spp_q   <= psa_pkg::SLOTS_RESET;
			head_q  <= LIST_END;
			pages_q <= '0;
		end else begin
			if (cfg_wr) begin
				spp_q <= pwdata[psa_pkg::CFG_W-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser[0] == psa_pkg::ACT_DELETE || head_q != LIST_END) begin
							state_q <= S_LOAD;
						end else if (pages_q == PW'(PAGES)) begin
							state_q <= S_RES;
						end else begin
							pages_q <= pages_q + PW'(1);
							state_q <= S_SCAN;
						end
					end
				end
				S_LOAD: begin
					if (act_q == psa_pkg::ACT_DELETE) begin
						if (!bad_c && rdata_q.cnt == '0) begin
							head_q <= ip_ext[PW-1:0];
						end
						state_q <= S_RES;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (byte_c != 8'hff || byte_q == BW'(NBYTES - 1)) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					head_q  <= (cnt_dec == '0) ? nxt_q : PW'(p_q);
					state_q <= S_RES;
				end
				S_RES: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				act_q      <= s_tuser[0];
				ipage_q    <= s_tdata[psa_pkg::PAGE_W-1:0];
				islot_q    <= s_tdata[psa_pkg::PAGE_W +: psa_pkg::SLOT_W];
				res_st_q   <= psa_pkg::ST_NO_PAGE;
				res_page_q <= s_tdata[psa_pkg::PAGE_W-1:0];
				res_slot_q <= s_tdata[psa_pkg::PAGE_W +: psa_pkg::SLOT_W];
				p_q        <= pages_q[AW-1:0];
				bits_q     <= '0;
				cnt_q      <= eff_c;
				nxt_q      <= LIST_END;
				byte_q     <= '0;
				if (head_q != LIST_END) begin
					p_q <= head_q[AW-1:0];
				end
			end
			S_LOAD: begin
				bits_q   <= rdata_q.bits;
				cnt_q    <= rdata_q.cnt;
				nxt_q    <= rdata_q.nxt;
				byte_q   <= '0;
				res_st_q <= bad_c ? psa_pkg::ST_BAD : psa_pkg::ST_OK;
			end
			S_SCAN: begin
				if (byte_c != 8'hff) begin
					slot_q <= found_c[SW-1:0];
				end else if (byte_q == BW'(NBYTES - 1)) begin
					slot_q <= SW'(SLOTS - 1);
				end else begin
					byte_q <= byte_q + BW'(1);
				end
			end
			S_WR: begin
				res_st_q   <= psa_pkg::ST_OK;
				res_page_q <= page_wide[psa_pkg::PAGE_W-1:0];
				res_slot_q <= slot_wide[psa_pkg::SLOT_W-1:0];
			end
			default: begin
				act_q <= act_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_st_q   <= res_st_q;
			out_page_q <= res_page_q;
			out_slot_q <= res_slot_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_st_q;
	assign m_tdata  = {4'd0, out_slot_q, out_page_q};

`ifndef NO_ASSERTIONS
	a_head_open: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == LIST_END) || (head_q < pages_q))
		else $error("list head names a page that was never opened");
	a_pages_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pages_q <= PW'(PAGES))
		else $error("open page count beyond the page store");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (byte_q <= BW'(NBYTES - 1)))
		else $error("slot scan ran past the last bitmap byte");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("new request taken while one is in progress");
	a_full_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |-> (cnt_q != '0))
		else $error("slot claimed in a page with no free slot");
`endif
endmodule
`default_nettype wire
